FILE: hw/rtl/mit_pkg.sv
// ----------------------------------------------------------------------------
// mit_pkg: shared types and constants of the mask intern table
// Table geometry, action codes, the command record that travels from the
// front to the back, and the index-to-handle conversion.
// ----------------------------------------------------------------------------
package mit_pkg;

    localparam int MASK_BITS   = 64;
    localparam int TABLE_DEPTH = 256;
    localparam int MASK_W      = 64;
    localparam int HANDLE_W    = 9;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int HC_W        = (CNT_W > HANDLE_W) ? CNT_W : HANDLE_W;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [HANDLE_W-1:0] NO_HANDLE = {HANDLE_W{1'b1}};

    typedef enum logic [1:0] {
        ACT_INTERN   = 2'd0,
        ACT_RETRIEVE = 2'd1,
        ACT_AND      = 2'd2
    } action_t;

    typedef logic signed [HANDLE_W-1:0] handle_t;
    typedef logic [MASK_W-1:0]          mask_t;

    typedef struct packed {
        action_t              action;
        logic [MASK_BITS-1:0] mask;
        logic                 a_neg;
        logic [HC_W-1:0]      a_idx;
        logic                 b_neg;
        logic [HC_W-1:0]      b_idx;
    } cmd_t;

    function automatic logic [HANDLE_W-1:0] idx_to_handle(input logic [HC_W-1:0] idx);
        return idx[HANDLE_W-1:0];
    endfunction

endpackage

FILE: hw/rtl/mit_if.sv
// ----------------------------------------------------------------------------
// mit_if: request and response channels of the mask intern table
// Valid/ready channels; a transaction moves when valid and ready are high.
// ----------------------------------------------------------------------------
interface mit_req_if import mit_pkg::*; ();
    logic          valid;
    logic          ready;
    logic [1:0]    action;
    mask_t         mask_value;
    handle_t       handle_a;
    handle_t       handle_b;

    modport source (output valid, action, mask_value, handle_a, handle_b, input ready);
    modport sink   (input valid, action, mask_value, handle_a, handle_b, output ready);
endinterface

interface mit_rsp_if import mit_pkg::*; ();
    logic          valid;
    logic          ready;
    handle_t       handle_out;
    mask_t         mask_out;
    logic          was_new;
    logic          table_full;

    modport source (output valid, handle_out, mask_out, was_new, table_full, input ready);
    modport sink   (input valid, handle_out, mask_out, was_new, table_full, output ready);
endinterface

FILE: hw/rtl/mit_front.sv
// ----------------------------------------------------------------------------
// mit_front: request decode
// Classify each request, drop unused actions, split handles into an empty
// flag and an unsigned index, and push a command into the queue.
// ----------------------------------------------------------------------------
module mit_front import mit_pkg::*; (
    mit_req_if.sink req,
    output logic    push_valid,
    input  logic    push_ready,
    output cmd_t    push_cmd
);

    logic known_action;

    always_comb
    begin
        case (req.action)
            ACT_INTERN, ACT_RETRIEVE, ACT_AND: known_action = 1'b1;
            default:                           known_action = 1'b0;
        endcase
    end

    // Unused actions are taken and dropped without a queue entry.
    assign req.ready  = push_ready;
    assign push_valid = req.valid && known_action;

    always_comb
    begin
        push_cmd.action = action_t'(req.action);
        push_cmd.mask   = req.mask_value[MASK_BITS-1:0];
        push_cmd.a_neg  = req.handle_a[HANDLE_W-1];
        push_cmd.a_idx  = HC_W'(req.handle_a[HANDLE_W-2:0]);
        push_cmd.b_neg  = req.handle_b[HANDLE_W-1];
        push_cmd.b_idx  = HC_W'(req.handle_b[HANDLE_W-2:0]);
    end

endmodule

FILE: hw/rtl/mit_cmd_fifo.sv
// ----------------------------------------------------------------------------
// mit_cmd_fifo: command queue between front and back
// Small register FIFO that decouples request intake from table work.
// ----------------------------------------------------------------------------
module mit_cmd_fifo import mit_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  cmd_t push_cmd,
    output logic pop_valid,
    input  logic pop_ready,
    output cmd_t pop_cmd
);

    cmd_t               slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic               do_push, do_pop;

    assign push_ready = (fill_reg != FILL_W'(QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_cmd    = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + FILL_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - FILL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

FILE: hw/rtl/mit_back.sv
// ----------------------------------------------------------------------------
// mit_back: table engine
// Hold the entry memory and fill count, read operands, scan for a match one
// entry per cycle, append on a miss, and drive the response register.
// ----------------------------------------------------------------------------
module mit_back import mit_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_ready,
    input  cmd_t      cmd,
    mit_rsp_if.source rsp
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_RDA  = 5'b00010,
        ST_RDB  = 5'b00100,
        ST_SCAN = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    logic [MASK_BITS-1:0] mem [TABLE_DEPTH];
    logic [MASK_BITS-1:0] rd_data_reg;

    state_t               state_reg, state_next;
    cmd_t                 cmd_reg, cmd_next;
    logic [MASK_BITS-1:0] key_reg, key_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     scan_reg, scan_next;
    logic                 pend_reg, pend_next;
    logic [IDX_W-1:0]     pend_idx_reg, pend_idx_next;
    logic [HANDLE_W-1:0]  res_handle_reg, res_handle_next;
    logic                 res_new_reg, res_new_next;
    logic                 res_full_reg, res_full_next;

    logic                 out_valid_reg, out_valid_next;
    logic [HANDLE_W-1:0]  out_handle_reg, out_handle_next;
    mask_t                out_mask_reg, out_mask_next;
    logic                 out_new_reg, out_new_next;
    logic                 out_full_reg, out_full_next;

    logic                 rd_en, wr_en, load_out, can_emit;
    logic [IDX_W-1:0]     rd_addr;
    logic                 a_ok, b_ok, hit;

    assign a_ok     = !cmd_reg.a_neg && (cmd_reg.a_idx < HC_W'(count_reg));
    assign b_ok     = !cmd_reg.b_neg && (cmd_reg.b_idx < HC_W'(count_reg));
    assign hit      = pend_reg && (rd_data_reg == key_reg);
    assign can_emit = !out_valid_reg || rsp.ready;

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        key_next        = key_reg;
        count_next      = count_reg;
        scan_next       = scan_reg;
        pend_next       = pend_reg;
        pend_idx_next   = pend_idx_reg;
        res_handle_next = res_handle_reg;
        res_new_next    = res_new_reg;
        res_full_next   = res_full_reg;
        rd_en           = 1'b0;
        rd_addr         = '0;
        wr_en           = 1'b0;
        load_out        = 1'b0;
        cmd_ready       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_ready = 1'b1;
                    cmd_next  = cmd;
                    case (cmd.action)
                        ACT_INTERN:
                        begin
                            key_next   = cmd.mask;
                            scan_next  = '0;
                            pend_next  = 1'b0;
                            state_next = ST_SCAN;
                        end
                        ACT_RETRIEVE, ACT_AND:
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = cmd.a_idx[IDX_W-1:0];
                            state_next = ST_RDA;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_RDA:
            begin
                // Out-of-range and empty handles read as zero.
                key_next = a_ok ? rd_data_reg : '0;
                if (cmd_reg.action == ACT_AND)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = cmd_reg.b_idx[IDX_W-1:0];
                    state_next = ST_RDB;
                end
                else
                begin
                    res_handle_next = '0;
                    res_new_next    = 1'b0;
                    res_full_next   = 1'b0;
                    state_next      = ST_DONE;
                end
            end
            ST_RDB:
            begin
                key_next   = key_reg & (b_ok ? rd_data_reg : '0);
                scan_next  = '0;
                pend_next  = 1'b0;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                // Compare the entry read last cycle while issuing the next read.
                if (hit)
                begin
                    res_handle_next = idx_to_handle(HC_W'(pend_idx_reg));
                    res_new_next    = 1'b0;
                    res_full_next   = 1'b0;
                    state_next      = ST_DONE;
                end
                else if (scan_reg < count_reg)
                begin
                    rd_en         = 1'b1;
                    rd_addr       = scan_reg[IDX_W-1:0];
                    pend_next     = 1'b1;
                    pend_idx_next = scan_reg[IDX_W-1:0];
                    scan_next     = scan_reg + CNT_W'(1);
                end
                else if (count_reg == CNT_W'(TABLE_DEPTH))
                begin
                    res_handle_next = NO_HANDLE;
                    res_new_next    = 1'b0;
                    res_full_next   = 1'b1;
                    state_next      = ST_DONE;
                end
                else
                begin
                    wr_en           = 1'b1;
                    res_handle_next = idx_to_handle(HC_W'(count_reg));
                    res_new_next    = 1'b1;
                    res_full_next   = 1'b0;
                    count_next      = count_reg + CNT_W'(1);
                    state_next      = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (can_emit)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_handle_next = out_handle_reg;
        out_mask_next   = out_mask_reg;
        out_new_next    = out_new_reg;
        out_full_next   = out_full_reg;
        if (load_out)
        begin
            out_valid_next  = 1'b1;
            out_handle_next = res_handle_reg;
            out_mask_next   = MASK_W'(key_reg);
            out_new_next    = res_new_reg;
            out_full_next   = res_full_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        key_reg        <= key_next;
        scan_reg       <= scan_next;
        pend_idx_reg   <= pend_idx_next;
        res_handle_reg <= res_handle_next;
        res_new_reg    <= res_new_next;
        res_full_reg   <= res_full_next;
        out_handle_reg <= out_handle_next;
        out_mask_reg   <= out_mask_next;
        out_new_reg    <= out_new_next;
        out_full_reg   <= out_full_next;
    end

    // Entry memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[count_reg[IDX_W-1:0]] <= key_reg;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.handle_out = $signed(out_handle_reg);
    assign rsp.mask_out   = out_mask_reg;
    assign rsp.was_new    = out_new_reg;
    assign rsp.table_full = out_full_reg;

endmodule

FILE: hw/rtl/mask_intern_table.sv
// ----------------------------------------------------------------------------
// mask_intern_table: interns bit masks into dense handles
// Intern, retrieve and AND-then-intern over an append-only table of masks.
// ----------------------------------------------------------------------------
//
//  channel  dir  transaction fields
//  -------  ---  ------------------------------------------------------------
//  req      in   action, mask_value, handle_a, handle_b
//  rsp      out  handle_out, mask_out, was_new, table_full
//
// Scan: intern and AND search the stored entries for a match; the scan reads
//   the entry memory through its single read port, one entry per cycle, and
//   compares as it goes, stopping early on a match.
// Reset: clears the fill count, the queue and the response valid. The entry
//   memory is not cleared; only entries below the fill count are ever used.
// Stalls: a two-entry command queue lets requests keep arriving while the
//   engine scans; the response register lets the engine finish the next
//   command while a response waits. Unused actions are taken and dropped.
// ----------------------------------------------------------------------------
module mask_intern_table import mit_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    mit_req_if.sink   req,
    mit_rsp_if.source rsp
);

    logic push_valid, push_ready;
    cmd_t push_cmd;
    logic pop_valid, pop_ready;
    cmd_t pop_cmd;

    // Decode requests into commands.
    mit_front u_front (
        .req        (req),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    // Hold commands while the engine is busy.
    mit_cmd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    // Execute commands against the table and drive responses.
    mit_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (pop_valid),
        .cmd_ready (pop_ready),
        .cmd       (pop_cmd),
        .rsp       (rsp)
    );

endmodule

FILE: hw/rtl/mit_checker.sv
// ----------------------------------------------------------------------------
// mit_checker: response channel checks
// Watch the response port: hold rules, handle numbering of new entries, and
// consistency of the full indication.
// ----------------------------------------------------------------------------
module mit_checker import mit_pkg::*; (
    input logic    clk,
    input logic    rst_n,
    input logic    rsp_valid,
    input logic    rsp_ready,
    input handle_t handle_out,
    input mask_t   mask_out,
    input logic    was_new,
    input logic    table_full
);

    logic [CNT_W-1:0] new_cnt_reg;

    // Count entries created, as seen on the response port.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            new_cnt_reg <= '0;
        end
        else if (rsp_valid && rsp_ready && was_new)
        begin
            new_cnt_reg <= new_cnt_reg + CNT_W'(1);
        end
    end

    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response valid dropped while stalled");

    a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(handle_out) && $stable(mask_out)
                                    && $stable(was_new) && $stable(table_full))
        else $error("response payload changed while stalled");

    a_new_handle: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && was_new |-> !table_full
            && handle_out == idx_to_handle(HC_W'(new_cnt_reg)))
        else $error("new entry handle out of sequence");

    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && table_full |-> handle_out == NO_HANDLE
            && new_cnt_reg == CNT_W'(TABLE_DEPTH))
        else $error("full indication inconsistent with entries created");

endmodule

bind mask_intern_table mit_checker u_mit_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .handle_out (rsp.handle_out),
    .mask_out   (rsp.mask_out),
    .was_new    (rsp.was_new),
    .table_full (rsp.table_full)
);
